/* rtl/stip_pkg.sv */
// package: defaults, character codes and digit decode for the string to integer parser
package stip_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int COUNT_BITS_DEF = 16;
    localparam int BASE_BITS      = 6;
    localparam int CHAR_BITS      = 8;

    localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
    localparam logic [BASE_BITS-1:0] BASE_OCT   = 6'd8;
    localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;

    localparam logic [CHAR_BITS-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE    = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_LC_A    = 8'h61;
    localparam logic [CHAR_BITS-1:0] CH_LC_Z    = 8'h7A;
    localparam logic [CHAR_BITS-1:0] CH_UC_A    = 8'h41;
    localparam logic [CHAR_BITS-1:0] CH_UC_Z    = 8'h5A;
    localparam logic [CHAR_BITS-1:0] CH_LC_X    = 8'h78;
    localparam logic [CHAR_BITS-1:0] CH_UC_X    = 8'h58;
    localparam logic [CHAR_BITS-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CHAR_BITS-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_BITS-1:0] LETTER_OFS = 8'd10;

    typedef struct packed {
        logic                 ok;
        logic [BASE_BITS-1:0] val;
    } t_digit;

    function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic t_digit digit_of(input logic [CHAR_BITS-1:0] c);
        t_digit                 d;
        logic [CHAR_BITS-1:0]   v;
        d.ok  = 1'b0;
        d.val = '0;
        v     = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v    = c - CH_ZERO;
            d.ok = 1'b1;
        end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
            v    = c - CH_LC_A + LETTER_OFS;
            d.ok = 1'b1;
        end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
            v    = c - CH_UC_A + LETTER_OFS;
            d.ok = 1'b1;
        end
        d.val = v[BASE_BITS-1:0];
        return d;
    endfunction

endpackage

/* rtl/string_to_integer_parser_unit.sv */
// top level: streaming strtol-style string to integer parser
//
// usage
// - s_* channel carries one character per word: s_tdata[7:0] is the character,
//   s_tuser marks the first character of a new string (restarts the parse)
// - m_* channel carries one word per finished string: value in the low
//   VALUE_BITS of m_tdata, characters consumed above it, zero padded to bytes
// - cfg channel writes the radix (0 = auto octal/decimal/hex); it is always
//   ready and the radix is sampled when a first character is parsed
// - a word is accepted into an input register and parsed from there against
//   the parse state; a stop character's result lands in the output register,
//   whose valid flag drives m_tvalid
// - throughput is one character per cycle while the parse is not held; the
//   loop that sets it is the accumulator update (one multiply by the radix plus one add)
// - a receiver stall only holds the parse when the pending character would
//   finish a string while the output register is still full
// - reset clears the parse to "done, waiting for a start", radix to ten,
//   and empties both registers; characters before any start are dropped
module string_to_integer_parser_unit #(
    parameter int VALUE_BITS = stip_pkg::VALUE_BITS_DEF,
    parameter int COUNT_BITS = stip_pkg::COUNT_BITS_DEF,
    parameter int OUT_WIDTH  = ((VALUE_BITS + COUNT_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // config write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [stip_pkg::BASE_BITS-1:0] i_cfg_data,   // number_base
    // character stream in
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [stip_pkg::CHAR_BITS-1:0] s_tdata,      // ch
    input  logic                           s_tuser,      // first
    // result stream out
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [OUT_WIDTH-1:0]           m_tdata       // value, chars_consumed, zero pad
);
    import stip_pkg::*;

    localparam int OUT_BITS = VALUE_BITS + COUNT_BITS;
    localparam int PROD_BITS = VALUE_BITS + BASE_BITS;

    // parse phases
    localparam logic [2:0] PH_DONE   = 3'd0;
    localparam logic [2:0] PH_SPACE  = 3'd1;
    localparam logic [2:0] PH_PREFIX = 3'd2;
    localparam logic [2:0] PH_ZERO   = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;

    // config
    logic [BASE_BITS-1:0]  r_base;

    // input register
    logic                  r_in_valid;
    logic [CHAR_BITS-1:0]  r_in_ch;
    logic                  r_in_first;

    // parse state
    logic [2:0]            r_phase,  n_phase;
    logic                  r_neg,    n_neg;
    logic [VALUE_BITS-1:0] r_acc,    n_acc;
    logic [BASE_BITS-1:0]  r_eb,     n_eb;
    logic [COUNT_BITS-1:0] r_pos,    n_pos;

    // output register
    logic                  r_out_valid;
    logic [OUT_WIDTH-1:0]  r_out_data, n_out_data;

    logic                  emit;
    logic                  stage_adv;
    logic                  out_free;
    logic                  in_take;
    logic                  adv_pos;
    logic                  do_prefix;
    logic                  do_digit;
    t_digit                dig;
    logic [PROD_BITS-1:0]  prod;
    logic [VALUE_BITS-1:0] res_value;
    logic [COUNT_BITS-1:0] base_pos;

    assign o_cfg_ready = 1'b1;

    assign out_free  = !r_out_valid || m_tready;
    assign stage_adv = r_in_valid && (!emit || out_free);
    assign s_tready  = !r_in_valid || stage_adv;
    assign in_take   = s_tvalid && s_tready;

    assign dig = digit_of(r_in_ch);

    // single pass over the registered character
    always_comb begin
        // a first character restarts the parse before it is looked at
        if (r_in_first) begin
            n_phase  = PH_SPACE;
            n_neg    = 1'b0;
            n_acc    = '0;
            n_eb     = r_base;
            base_pos = '0;
        end else begin
            n_phase  = r_phase;
            n_neg    = r_neg;
            n_acc    = r_acc;
            n_eb     = r_eb;
            base_pos = r_pos;
        end
        adv_pos   = 1'b0;
        do_prefix = 1'b0;
        do_digit  = 1'b0;
        emit      = 1'b0;
        res_value = '0;
        prod      = '0;

        case (n_phase)
            PH_SPACE: begin
                if (is_space(r_in_ch)) begin
                    adv_pos = 1'b1;
                end else if (r_in_ch == CH_MINUS || r_in_ch == CH_PLUS) begin
                    n_neg   = (r_in_ch == CH_MINUS);
                    adv_pos = 1'b1;
                    n_phase = PH_PREFIX;
                end else begin
                    do_prefix = 1'b1;
                end
            end
            PH_PREFIX: begin
                do_prefix = 1'b1;
            end
            PH_ZERO: begin
                n_acc = '0;
                if (r_in_ch == CH_LC_X || r_in_ch == CH_UC_X) begin
                    n_eb    = BASE_HEX;
                    adv_pos = 1'b1;
                    n_phase = PH_DIGITS;
                end else begin
                    n_eb     = (n_eb == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                    n_phase  = PH_DIGITS;
                    do_digit = 1'b1;
                end
            end
            PH_DIGITS: begin
                do_digit = 1'b1;
            end
            default: begin
            end
        endcase

        // leading zero may start a 0x prefix for auto and hex radix
        if (do_prefix) begin
            if ((n_eb == BASE_AUTO || n_eb == BASE_HEX) && r_in_ch == CH_ZERO) begin
                adv_pos = 1'b1;
                n_phase = PH_ZERO;
            end else begin
                if (n_eb == BASE_AUTO) begin
                    n_eb = BASE_DEC;
                end
                n_phase  = PH_DIGITS;
                do_digit = 1'b1;
            end
        end

        if (do_digit) begin
            if (!dig.ok || dig.val >= n_eb) begin
                emit      = 1'b1;
                res_value = n_neg ? (~n_acc + VALUE_BITS'(1)) : n_acc;
                n_phase   = PH_DONE;
            end else begin
                prod    = PROD_BITS'(n_acc) * PROD_BITS'(n_eb);
                n_acc   = prod[VALUE_BITS-1:0] + VALUE_BITS'(dig.val);
                adv_pos = 1'b1;
            end
        end

        // position saturates at all ones
        n_pos = (adv_pos && base_pos != '1) ? base_pos + COUNT_BITS'(1) : base_pos;
    end

    always_comb begin
        n_out_data = '0;
        n_out_data[VALUE_BITS-1:0]        = res_value;
        n_out_data[OUT_BITS-1:VALUE_BITS] = base_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_RESET;
            r_in_valid  <= 1'b0;
            r_phase     <= PH_DONE;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_eb        <= BASE_RESET;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_base <= i_cfg_data;
            end
            if (s_tready) begin
                r_in_valid <= s_tvalid;
            end
            if (stage_adv) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
                r_eb    <= n_eb;
                r_pos   <= n_pos;
            end
            if (out_free) begin
                r_out_valid <= stage_adv && emit;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_ch    <= s_tdata;
            r_in_first <= s_tuser;
        end
        if (stage_adv && emit) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    // a finished string leaves the parse in the done phase
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_adv && emit |=> r_phase == PH_DONE)
        else $error("parse not done after result");

    // once done, nothing is produced until a new start
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_phase == PH_DONE && !r_in_first |-> !emit)
        else $error("result produced without a start");

    // the parse only holds when a result meets a full, stalled output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !stage_adv |-> emit && r_out_valid && !m_tready)
        else $error("parse stalled without a full output");

    // within a string the position never moves back
    a_pos_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_adv && !r_in_first |=> r_pos >= $past(r_pos))
        else $error("position decreased within a string");

    // a produced result is registered in the output register and flagged valid
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stage_adv && emit |=> r_out_valid)
        else $error("result lost");
`endif

endmodule
